[sv/dsbr_pkg.sv]
// dsbr_pkg: shared widths, instruction and hazard codes, and pipeline records
// for the decode and branch resolve stage. No dependencies.
`default_nettype none

package dsbr_pkg;

  localparam int REG_COUNT_DEF  = 32;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int IDX_W = 5;
  localparam int ID_W  = 6;
  localparam int IMM_W = 16;
  localparam int JF_W  = 26;
  localparam int PC_W  = 32;
  localparam int VAL_W = 32;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam id_t ID_NOP  = 6'd0;
  localparam id_t ID_JR   = 6'd1;
  localparam id_t ID_BEQ  = 6'd2;
  localparam id_t ID_BNE  = 6'd3;
  localparam id_t ID_BGTZ = 6'd4;
  localparam id_t ID_J    = 6'd5;
  localparam id_t ID_JAL  = 6'd6;

  localparam idx_t LINK_REG = 5'd31;

  typedef enum logic {
    OP_DECODE,
    OP_WRITEBACK
  } op_t;

  typedef enum logic [1:0] {
    HZ_NONE,
    HZ_FWD_A,
    HZ_FWD_B,
    HZ_STALL
  } hazard_t;

  typedef struct packed {
    id_t                     id;
    idx_t                    rs;
    idx_t                    rt;
    idx_t                    rd;
    idx_t                    shamt;
    logic signed [IMM_W-1:0] imm;
    logic [JF_W-1:0]         jf;
    logic [PC_W-1:0]         pc;
    hazard_t                 hz;
    logic [VAL_W-1:0]        byp;
    logic                    wr;
    logic                    a_ok;
    logic                    b_ok;
    logic                    d_ok;
  } item_t;

  typedef struct packed {
    id_t                     id;
    idx_t                    rs;
    idx_t                    rt;
    idx_t                    rd;
    idx_t                    shamt;
    logic signed [IMM_W-1:0] imm;
    logic [JF_W-1:0]         jf;
    logic                    reg_write;
    logic [VAL_W-1:0]        a_val;
    logic [VAL_W-1:0]        b_val;
    logic [VAL_W-1:0]        d_val;
    logic [PC_W-1:0]         next_pc;
  } res_t;

endpackage

`default_nettype wire

[sv/dsbr_ram.sv]
// dsbr_ram: generic synchronous ram, one write port and RD_PORTS read ports,
// registered read that returns the old word on a same-cycle write. No dependencies.
`default_nettype none

module dsbr_ram #(
  parameter int WIDTH    = 32,
  parameter int DEPTH    = 32,
  parameter int RD_PORTS = 2,
  localparam int AW      = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [AW-1:0]                      wr_addr,
  input  logic [WIDTH-1:0]                   wr_data,
  input  logic                               rd_en,
  input  logic [RD_PORTS-1:0][AW-1:0]        rd_addr,
  output logic [RD_PORTS-1:0][WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0]                 mem_r [DEPTH];
  logic [RD_PORTS-1:0][WIDTH-1:0]   rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      for (int p = 0; p < RD_PORTS; p++) begin
        rd_data_r[p] <= mem_r[rd_addr[p]];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/decode_stage_branch_resolve_core.sv]
// decode_stage_branch_resolve_core: register file decode stage with operand
// bypass, bubble insertion and branch / jump resolution.
// Depends on dsbr_pkg and dsbr_ram.
//
// Usage:
//   in_* channel takes one request per cycle: a decode request reads rs, rt and
//   rd, a writeback request writes in_bypass_or_write_value to rd and gives no
//   result. out_* channel gives one result per decode request, in order.
//   Both channels use valid / stall; a request moves when valid is high and
//   stall is low.
// Pipeline: a decode result passes the ram read stage, then the output register.
//   Throughput is one request per cycle while no stall holds the pipe, bounded
//   by the register file rams, which each take one write and their reads each
//   cycle. Writes (writeback data or the jal link) land in the rams at the
//   edge the request is taken, so the next request already sees them.
// Reset: synchronous, active low; the register file reads as all zeros until a
//   register is written (one valid bit per register), the pipe empties.
// Receiver stall: the output register holds; one more decode request is taken
//   into the read stage, then in_stall rises until the output drains.
`default_nettype none

module decode_stage_branch_resolve_core
  import dsbr_pkg::*;
#(
  parameter int REGISTER_COUNT = REG_COUNT_DEF,
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_operation,
  input  logic [ID_W-1:0]         in_instr_id,
  input  logic [IDX_W-1:0]        in_src_a_index,
  input  logic [IDX_W-1:0]        in_src_b_index,
  input  logic [IDX_W-1:0]        in_dest_index,
  input  logic [IDX_W-1:0]        in_shift_amount,
  input  logic signed [IMM_W-1:0] in_imm_value,
  input  logic [JF_W-1:0]         in_jump_field,
  input  logic [PC_W-1:0]         in_current_pc,
  input  logic [1:0]              in_hazard_code,
  input  logic [VAL_W-1:0]        in_bypass_or_write_value,
  input  logic                    in_writes_register,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ID_W-1:0]         out_instr_id,
  output logic [IDX_W-1:0]        out_src_a_index,
  output logic [IDX_W-1:0]        out_src_b_index,
  output logic [IDX_W-1:0]        out_dest_index,
  output logic [IDX_W-1:0]        out_shift_amount,
  output logic signed [IMM_W-1:0] out_imm_value,
  output logic [JF_W-1:0]         out_jump_field,
  output logic                    out_reg_write,
  output logic [VAL_W-1:0]        out_src_a_value,
  output logic [VAL_W-1:0]        out_src_b_value,
  output logic [VAL_W-1:0]        out_dest_value,
  output logic [PC_W-1:0]         out_next_pc
);

  localparam int          AW = $clog2(REGISTER_COUNT);
  localparam int          DW = DATA_WIDTH;
  localparam int unsigned RC = REGISTER_COUNT;

  function automatic logic idx_ok(input idx_t idx);
    return (idx != '0) && (32'(idx) < RC);
  endfunction

  op_t                     in_op;
  hazard_t                 in_hz;
  logic                    in_acc;
  logic                    s1_adv;

  logic [REGISTER_COUNT-1:0] vld_r;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [DW-1:0]           wr_data;
  logic                    rd_en;
  logic [1:0][AW-1:0]      ab_addr;
  logic [0:0][AW-1:0]      d_addr;
  logic [1:0][DW-1:0]      ab_data;
  logic [0:0][DW-1:0]      d_data;

  logic                    s1_valid_r;
  item_t                   s1_r;
  item_t                   s1_nxt;

  logic                    out_valid_r;
  res_t                    res_r;
  res_t                    res_nxt;

  logic [DW-1:0]           a_val;
  logic [DW-1:0]           b_val;
  logic [DW-1:0]           d_val;
  logic [PC_W-1:0]         offset;
  logic [PC_W-1:0]         br_tgt;
  logic [PC_W-1:0]         jmp_tgt;

  assign in_op  = op_t'(in_operation);
  assign in_hz  = hazard_t'(in_hazard_code);
  assign s1_adv = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc = in_valid && !in_stall;

  // writes land at accept time
  always_comb begin
    if (in_op == OP_WRITEBACK) begin
      wr_en   = in_acc && idx_ok(in_dest_index);
      wr_addr = AW'(in_dest_index);
      wr_data = DW'(in_bypass_or_write_value);
    end else begin
      wr_en   = in_acc && (in_instr_id == ID_JAL) && (in_hz != HZ_STALL)
                && idx_ok(LINK_REG);
      wr_addr = AW'(LINK_REG);
      wr_data = DW'(in_current_pc);
    end
  end

  assign rd_en      = in_acc && (in_op == OP_DECODE);
  assign ab_addr[0] = AW'(in_src_a_index);
  assign ab_addr[1] = AW'(in_src_b_index);
  assign d_addr[0]  = AW'(in_dest_index);

  dsbr_ram #(
    .WIDTH    (DW),
    .DEPTH    (REGISTER_COUNT),
    .RD_PORTS (2)
  ) u_ram_ab (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (ab_addr),
    .rd_data (ab_data)
  );

  dsbr_ram #(
    .WIDTH    (DW),
    .DEPTH    (REGISTER_COUNT),
    .RD_PORTS (1)
  ) u_ram_d (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (d_addr),
    .rd_data (d_data)
  );

  always_comb begin
    s1_nxt.id    = in_instr_id;
    s1_nxt.rs    = in_src_a_index;
    s1_nxt.rt    = in_src_b_index;
    s1_nxt.rd    = in_dest_index;
    s1_nxt.shamt = in_shift_amount;
    s1_nxt.imm   = in_imm_value;
    s1_nxt.jf    = in_jump_field;
    s1_nxt.pc    = in_current_pc;
    s1_nxt.hz    = in_hz;
    s1_nxt.byp   = in_bypass_or_write_value;
    s1_nxt.wr    = in_writes_register;
    s1_nxt.a_ok  = idx_ok(in_src_a_index) && vld_r[AW'(in_src_a_index)];
    s1_nxt.b_ok  = idx_ok(in_src_b_index) && vld_r[AW'(in_src_b_index)];
    s1_nxt.d_ok  = idx_ok(in_dest_index) && vld_r[AW'(in_dest_index)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (in_acc) begin
        s1_valid_r <= (in_op == OP_DECODE);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  // operand select, branch resolve
  always_comb begin
    a_val = s1_r.a_ok ? ab_data[0] : '0;
    b_val = s1_r.b_ok ? ab_data[1] : '0;
    d_val = s1_r.d_ok ? d_data[0] : '0;
    if (s1_r.hz == HZ_FWD_A) begin
      a_val = DW'(s1_r.byp);
    end
    if (s1_r.hz == HZ_FWD_B) begin
      b_val = DW'(s1_r.byp);
    end

    offset  = {{(PC_W-IMM_W-2){s1_r.imm[IMM_W-1]}}, s1_r.imm, 2'b00};
    br_tgt  = s1_r.pc + offset;
    jmp_tgt = {s1_r.pc[PC_W-1:PC_W-4], s1_r.jf, 2'b00};

    res_nxt.id        = ID_NOP;
    res_nxt.rs        = '0;
    res_nxt.rt        = '0;
    res_nxt.rd        = '0;
    res_nxt.shamt     = '0;
    res_nxt.imm       = '0;
    res_nxt.jf        = '0;
    res_nxt.reg_write = 1'b0;
    res_nxt.a_val     = VAL_W'(a_val);
    res_nxt.b_val     = VAL_W'(b_val);
    res_nxt.d_val     = VAL_W'(d_val);
    res_nxt.next_pc   = s1_r.pc;

    if (s1_r.hz != HZ_STALL) begin
      res_nxt.id        = s1_r.id;
      res_nxt.rs        = s1_r.rs;
      res_nxt.rt        = s1_r.rt;
      res_nxt.rd        = s1_r.rd;
      res_nxt.shamt     = s1_r.shamt;
      res_nxt.imm       = s1_r.imm;
      res_nxt.jf        = s1_r.jf;
      res_nxt.reg_write = s1_r.wr;
      case (s1_r.id)
        ID_JR: begin
          res_nxt.next_pc = PC_W'(a_val);
        end
        ID_BEQ: begin
          if (a_val == b_val) begin
            res_nxt.next_pc = br_tgt;
          end
        end
        ID_BNE: begin
          if (a_val != b_val) begin
            res_nxt.next_pc = br_tgt;
          end
        end
        ID_BGTZ: begin
          if (!a_val[DW-1] && (a_val != '0)) begin
            res_nxt.next_pc = br_tgt;
          end
        end
        ID_J, ID_JAL: begin
          res_nxt.next_pc = jmp_tgt;
        end
        default: begin
          res_nxt.next_pc = s1_r.pc;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_instr_id     = res_r.id;
  assign out_src_a_index  = res_r.rs;
  assign out_src_b_index  = res_r.rt;
  assign out_dest_index   = res_r.rd;
  assign out_shift_amount = res_r.shamt;
  assign out_imm_value    = res_r.imm;
  assign out_jump_field   = res_r.jf;
  assign out_reg_write    = res_r.reg_write;
  assign out_src_a_value  = res_r.a_val;
  assign out_src_b_value  = res_r.b_val;
  assign out_dest_value   = res_r.d_val;
  assign out_next_pc      = res_r.next_pc;

endmodule

`default_nettype wire

[sv/dsbr_chk.sv]
// dsbr_chk: port level checks for decode_stage_branch_resolve_core, bound in below.
// Depends on dsbr_pkg.
`default_nettype none

module dsbr_chk
  import dsbr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ID_W-1:0]   out_instr_id,
  input logic [JF_W-1:0]   out_jump_field,
  input logic [VAL_W-1:0]  out_src_a_value,
  input logic [PC_W-1:0]   out_next_pc
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("request stalled with output free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_pc) && $stable(out_instr_id))
    else $error("stalled result changed");

  a_jump_tgt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_instr_id == ID_J || out_instr_id == ID_JAL)
    |-> out_next_pc[JF_W+1:2] == out_jump_field && out_next_pc[1:0] == 2'b00)
    else $error("jump target mismatch");

  a_jr_tgt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_instr_id == ID_JR |-> out_next_pc == out_src_a_value)
    else $error("jr target mismatch");

endmodule

bind decode_stage_branch_resolve_core dsbr_chk u_dsbr_chk (.*);

`default_nettype wire

[sim/tb_decode_stage_branch_resolve_core.sv]
// testbench for decode_stage_branch_resolve_core: directed and random requests with idling and
// back-pressure, each result checked against an in-order prediction of the register file.
// depends on dsbr_pkg and the decode_stage_branch_resolve_core rtl.
`timescale 1ns / 1ps

module tb_decode_stage_branch_resolve_core;
  import dsbr_pkg::*;

  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_TAIL     = 4;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 400;

  typedef struct {
    op_t                     op;
    id_t                     id;
    idx_t                    rs;
    idx_t                    rt;
    idx_t                    rd;
    idx_t                    shamt;
    logic signed [IMM_W-1:0] imm;
    logic [JF_W-1:0]         jf;
    logic [PC_W-1:0]         pc;
    hazard_t                 hz;
    logic [VAL_W-1:0]        byp;
    logic                    wr;
  } request_t;

  class decode_scoreboard;
    logic [VAL_W-1:0] shadow_regs [REG_COUNT_DEF];
    res_t expected_decodes[$];
    int fails, results_checked;
    int decodes, writebacks, bubbles, forwards, taken, not_taken, jumps, links;

    function new();
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
    endfunction

    function logic [VAL_W-1:0] reg_value(idx_t i);
      return (i == 0) ? '0 : shadow_regs[i];
    endfunction

    function void note_request(request_t r);
      res_t e;
      logic [VAL_W-1:0] a, b;
      logic [PC_W-1:0] offset;
      logic branch_taken;
      if (r.op == OP_WRITEBACK) begin
        if (r.rd != 0) shadow_regs[r.rd] = r.byp;
        writebacks++;
        return;
      end
      decodes++;
      a = (r.hz == HZ_FWD_A) ? r.byp : reg_value(r.rs);
      b = (r.hz == HZ_FWD_B) ? r.byp : reg_value(r.rt);
      e = '0;
      e.a_val = a;
      e.b_val = b;
      e.d_val = reg_value(r.rd);
      e.next_pc = r.pc;
      if (r.hz == HZ_STALL) begin
        bubbles++;
        expected_decodes.push_back(e);
        return;
      end
      if (r.hz != HZ_NONE) forwards++;
      offset = {{(PC_W-IMM_W-2){r.imm[IMM_W-1]}}, r.imm, 2'b00};
      case (r.id)
        ID_JR: begin
          e.next_pc = a;
          jumps++;
        end
        ID_BEQ, ID_BNE, ID_BGTZ: begin
          if (r.id == ID_BEQ) branch_taken = (a == b);
          else if (r.id == ID_BNE) branch_taken = (a != b);
          else branch_taken = !a[VAL_W-1] && (a != '0);
          if (branch_taken) begin
            e.next_pc = r.pc + offset;
            taken++;
          end else begin
            not_taken++;
          end
        end
        ID_J: begin
          e.next_pc = {r.pc[PC_W-1 -: 4], r.jf, 2'b00};
          jumps++;
        end
        ID_JAL: begin
          shadow_regs[LINK_REG] = r.pc;
          e.next_pc = {r.pc[PC_W-1 -: 4], r.jf, 2'b00};
          links++;
        end
        default: ;
      endcase
      e.id = r.id;
      e.rs = r.rs;
      e.rt = r.rt;
      e.rd = r.rd;
      e.shamt = r.shamt;
      e.imm = r.imm;
      e.jf = r.jf;
      e.reg_write = r.wr;
      expected_decodes.push_back(e);
    endfunction

    function int field_differs(string name, logic [31:0] e, logic [31:0] g);
      if (g === e) return 0;
      if (fails < MAX_REPORTS)
        $display("result %0d: %s expected %h got %h", results_checked, name, e, g);
      return 1;
    endfunction

    function void check_result(res_t got);
      res_t e;
      int bad;
      results_checked++;
      if (expected_decodes.size() == 0) begin
        if (fails < MAX_REPORTS) $display("result %0d: none expected, got %p", results_checked, got);
        fails++;
        return;
      end
      e = expected_decodes.pop_front();
      bad = 0;
      bad += field_differs("instr_id", e.id, got.id);
      bad += field_differs("src_a_index", e.rs, got.rs);
      bad += field_differs("src_b_index", e.rt, got.rt);
      bad += field_differs("dest_index", e.rd, got.rd);
      bad += field_differs("shift_amount", e.shamt, got.shamt);
      bad += field_differs("imm_value", e.imm, got.imm);
      bad += field_differs("jump_field", e.jf, got.jf);
      bad += field_differs("reg_write", e.reg_write, got.reg_write);
      bad += field_differs("src_a_value", e.a_val, got.a_val);
      bad += field_differs("src_b_value", e.b_val, got.b_val);
      bad += field_differs("dest_value", e.d_val, got.d_val);
      bad += field_differs("next_pc", e.next_pc, got.next_pc);
      if (bad != 0) fails++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_operation = 1'b0;
  logic [ID_W-1:0]         in_instr_id = '0;
  logic [IDX_W-1:0]        in_src_a_index = '0;
  logic [IDX_W-1:0]        in_src_b_index = '0;
  logic [IDX_W-1:0]        in_dest_index = '0;
  logic [IDX_W-1:0]        in_shift_amount = '0;
  logic signed [IMM_W-1:0] in_imm_value = '0;
  logic [JF_W-1:0]         in_jump_field = '0;
  logic [PC_W-1:0]         in_current_pc = '0;
  logic [1:0]              in_hazard_code = '0;
  logic [VAL_W-1:0]        in_bypass_or_write_value = '0;
  logic                    in_writes_register = 1'b0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ID_W-1:0]         out_instr_id;
  logic [IDX_W-1:0]        out_src_a_index;
  logic [IDX_W-1:0]        out_src_b_index;
  logic [IDX_W-1:0]        out_dest_index;
  logic [IDX_W-1:0]        out_shift_amount;
  logic signed [IMM_W-1:0] out_imm_value;
  logic [JF_W-1:0]         out_jump_field;
  logic                    out_reg_write;
  logic [VAL_W-1:0]        out_src_a_value;
  logic [VAL_W-1:0]        out_src_b_value;
  logic [VAL_W-1:0]        out_dest_value;
  logic [PC_W-1:0]         out_next_pc;

  decode_scoreboard sb;
  res_t seen_result;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int quiet_cycles = 0;

  decode_stage_branch_resolve_core dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_operation             (in_operation),
    .in_instr_id              (in_instr_id),
    .in_src_a_index           (in_src_a_index),
    .in_src_b_index           (in_src_b_index),
    .in_dest_index            (in_dest_index),
    .in_shift_amount          (in_shift_amount),
    .in_imm_value             (in_imm_value),
    .in_jump_field            (in_jump_field),
    .in_current_pc            (in_current_pc),
    .in_hazard_code           (in_hazard_code),
    .in_bypass_or_write_value (in_bypass_or_write_value),
    .in_writes_register       (in_writes_register),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_instr_id             (out_instr_id),
    .out_src_a_index          (out_src_a_index),
    .out_src_b_index          (out_src_b_index),
    .out_dest_index           (out_dest_index),
    .out_shift_amount         (out_shift_amount),
    .out_imm_value            (out_imm_value),
    .out_jump_field           (out_jump_field),
    .out_reg_write            (out_reg_write),
    .out_src_a_value          (out_src_a_value),
    .out_src_b_value          (out_src_b_value),
    .out_dest_value           (out_dest_value),
    .out_next_pc              (out_next_pc)
  );

  always #1 clk = ~clk;

  function automatic request_t random_request();
    request_t r;
    r.op = ($urandom_range(99) < 25) ? OP_WRITEBACK : OP_DECODE;
    r.id = ($urandom_range(99) < 70) ? id_t'($urandom_range(ID_JAL)) : id_t'($urandom);
    r.rs = idx_t'($urandom);
    r.rt = ($urandom_range(3) == 0) ? r.rs : idx_t'($urandom);
    r.rd = idx_t'($urandom);
    r.shamt = idx_t'($urandom);
    case ($urandom_range(9))
      0: r.imm = 16'sh7fff;
      1: r.imm = 16'sh8000;
      default: r.imm = IMM_W'($urandom);
    endcase
    r.jf = JF_W'($urandom);
    r.pc = $urandom;
    r.hz = hazard_t'($urandom_range(3));
    // small value pool so compares often hit equal and sign edges
    case ($urandom_range(9))
      0: r.byp = '0;
      1: r.byp = 32'h0000_0001;
      2: r.byp = 32'h8000_0000;
      3: r.byp = 32'h7fff_ffff;
      4: r.byp = '1;
      default: r.byp = $urandom;
    endcase
    r.wr = 1'($urandom);
    return r;
  endfunction

  function automatic request_t writeback_req(idx_t rd, logic [VAL_W-1:0] val);
    request_t r;
    r = random_request();
    r.op = OP_WRITEBACK;
    r.rd = rd;
    r.byp = val;
    return r;
  endfunction

  function automatic request_t decode_req(id_t id, idx_t rs, idx_t rt, idx_t rd, hazard_t hz,
                                          logic [VAL_W-1:0] byp, logic [PC_W-1:0] pc,
                                          logic signed [IMM_W-1:0] imm);
    request_t r;
    r = random_request();
    r.op = OP_DECODE;
    r.id = id;
    r.rs = rs;
    r.rt = rt;
    r.rd = rd;
    r.hz = hz;
    r.byp = byp;
    r.pc = pc;
    r.imm = imm;
    return r;
  endfunction

  task automatic send_request(input request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= r.op;
    in_instr_id <= r.id;
    in_src_a_index <= r.rs;
    in_src_b_index <= r.rt;
    in_dest_index <= r.rd;
    in_shift_amount <= r.shamt;
    in_imm_value <= r.imm;
    in_jump_field <= r.jf;
    in_current_pc <= r.pc;
    in_hazard_code <= r.hz;
    in_bypass_or_write_value <= r.byp;
    in_writes_register <= r.wr;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (sb.expected_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // receiver: random stall, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_done++;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_result = '{id: out_instr_id, rs: out_src_a_index, rt: out_src_b_index,
                      rd: out_dest_index, shamt: out_shift_amount, imm: out_imm_value,
                      jf: out_jump_field, reg_write: out_reg_write,
                      a_val: out_src_a_value, b_val: out_src_b_value,
                      d_val: out_dest_value, next_pc: out_next_pc};
      sb.check_result(seen_result);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    request_t r;
    int i;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 56;
    send_request(writeback_req(5'd1, 32'hffff_ffff));
    send_request(writeback_req(5'd2, 32'h8000_0000));
    send_request(writeback_req(5'd3, 32'h0000_0001));
    // register zero ignores writes
    send_request(writeback_req(5'd0, 32'hdead_beef));
    send_request(writeback_req(LINK_REG, 32'h7fff_ffff));
    r = decode_req(6'd63, 5'd0, 5'd1, 5'd31, HZ_NONE, '1, '1, 16'sh7fff);
    r.shamt = '1;
    r.jf = '1;
    r.wr = 1'b1;
    send_request(r);
    r = decode_req(ID_NOP, 5'd0, 5'd0, 5'd0, HZ_NONE, '0, '0, 16'sh0000);
    r.shamt = '0;
    r.jf = '0;
    r.wr = 1'b0;
    send_request(r);
    // branch targets wrapping both ways
    send_request(decode_req(ID_BEQ, 5'd1, 5'd1, 5'd2, HZ_NONE, '0, 32'hffff_fffc, 16'sh7fff));
    send_request(decode_req(ID_BEQ, 5'd1, 5'd3, 5'd2, HZ_NONE, '0, 32'h0, 16'sh8000));
    send_request(decode_req(ID_BNE, 5'd1, 5'd3, 5'd4, HZ_NONE, '0, 32'h0, 16'sh8000));
    send_request(decode_req(ID_BNE, 5'd2, 5'd2, 5'd4, HZ_NONE, '0, 32'h100, 16'sh0010));
    // bgtz on negative, positive, zero and largest positive
    send_request(decode_req(ID_BGTZ, 5'd2, 5'd0, 5'd1, HZ_NONE, '0, 32'h400, 16'sh0004));
    send_request(decode_req(ID_BGTZ, 5'd3, 5'd0, 5'd1, HZ_NONE, '0, 32'h400, -16'sd1));
    send_request(decode_req(ID_BGTZ, 5'd0, 5'd0, 5'd1, HZ_NONE, '0, 32'h400, 16'sh0004));
    send_request(decode_req(ID_BGTZ, 5'd31, 5'd0, 5'd1, HZ_NONE, '0, 32'h400, 16'sh0004));
    send_request(decode_req(ID_JR, 5'd1, 5'd2, 5'd3, HZ_NONE, '0, 32'h1000, 16'sh0));
    r = decode_req(ID_J, 5'd4, 5'd5, 5'd6, HZ_NONE, '0, 32'hf000_0000, 16'sh0);
    r.jf = '1;
    send_request(r);
    r = decode_req(ID_JAL, 5'd4, 5'd5, 5'd31, HZ_NONE, '0, 32'ha000_0004, 16'sh0);
    r.jf = '0;
    send_request(r);
    // link register visible right after jal
    send_request(decode_req(6'd7, 5'd31, 5'd31, 5'd31, HZ_NONE, '0, 32'h20, 16'sh1));
    send_request(decode_req(ID_BEQ, 5'd0, 5'd3, 5'd0, HZ_FWD_A, 32'h1, 32'h80, 16'sh0008));
    send_request(decode_req(ID_BNE, 5'd0, 5'd9, 5'd0, HZ_FWD_B, 32'h0, 32'h80, 16'sh0008));
    send_request(decode_req(ID_JR, 5'd1, 5'd0, 5'd0, HZ_FWD_A, 32'h1234_5678, 32'h80, 16'sh0));
    // bubble: no link, no branch
    send_request(decode_req(ID_JAL, 5'd1, 5'd2, 5'd31, HZ_STALL, '1, 32'h5000_0000, 16'sh0));
    send_request(decode_req(6'd9, 5'd31, 5'd1, 5'd31, HZ_NONE, '0, 32'h40, 16'sh0));
    send_request(decode_req(ID_BGTZ, 5'd3, 5'd3, 5'd3, HZ_STALL, '0, 32'h40, 16'sh0010));
    pause_until_drained();

    for (i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 3) holds_asked++;
      send_request(random_request());
    end
    pause_until_drained();

    send_idle_pct = 56;
    recv_idle_pct = 18;
    for (i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 2) pause_until_drained();
      if (i == 3 * PHASE_ITEMS / 4) holds_asked++;
      send_request(random_request());
    end
    pause_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 4) holds_asked++;
      send_request(random_request());
    end
    pause_until_drained();

    $display("covered %0d decodes and %0d writebacks over three idle mixes and %0d hold-offs",
             sb.decodes, sb.writebacks, holds_done);
    $display("branches %0d taken / %0d not, %0d jumps, %0d links, %0d bubbles, %0d forwards",
             sb.taken, sb.not_taken, sb.jumps, sb.links, sb.bubbles, sb.forwards);
    if (sb.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatched results", sb.fails);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
